// ----- hw/rtl/cbiq_pkg.sv -----
// Shared constants and register indexes for the complex biquad filter unit.
package cbiq_pkg;

    localparam int COEF_WIDTH_DEF   = 18;
    localparam int SAMPLE_WIDTH_DEF = 16;

    localparam int FRAC_W    = 5;
    localparam int CFG_IDX_W = 3;

    localparam logic [FRAC_W-1:0] FRAC_BITS_RESET = FRAC_W'(16);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_B0        = 3'd0,
        CFG_B1        = 3'd1,
        CFG_B2        = 3'd2,
        CFG_A1        = 3'd3,
        CFG_A2        = 3'd4,
        CFG_FRAC_BITS = 3'd5
    } t_cfg_idx;

endpackage

// ----- hw/rtl/cbiq_cfg.sv -----
// Coefficient and shift registers written through the configuration port.
module cbiq_cfg #(
    parameter int COEF_WIDTH = cbiq_pkg::COEF_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cbiq_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [COEF_WIDTH-1:0]             i_cfg_data,
    output logic signed [COEF_WIDTH-1:0]      o_b0,
    output logic signed [COEF_WIDTH-1:0]      o_b1,
    output logic signed [COEF_WIDTH-1:0]      o_b2,
    output logic signed [COEF_WIDTH-1:0]      o_a1,
    output logic signed [COEF_WIDTH-1:0]      o_a2,
    output logic [cbiq_pkg::FRAC_W-1:0]       o_frac
);

    logic signed [COEF_WIDTH-1:0] r_b0, r_b1, r_b2, r_a1, r_a2;
    logic [cbiq_pkg::FRAC_W-1:0]  r_frac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0   <= '0;
            r_b1   <= '0;
            r_b2   <= '0;
            r_a1   <= '0;
            r_a2   <= '0;
            r_frac <= cbiq_pkg::FRAC_BITS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                cbiq_pkg::CFG_B0:        r_b0   <= i_cfg_data;
                cbiq_pkg::CFG_B1:        r_b1   <= i_cfg_data;
                cbiq_pkg::CFG_B2:        r_b2   <= i_cfg_data;
                cbiq_pkg::CFG_A1:        r_a1   <= i_cfg_data;
                cbiq_pkg::CFG_A2:        r_a2   <= i_cfg_data;
                cbiq_pkg::CFG_FRAC_BITS: r_frac <= i_cfg_data[cbiq_pkg::FRAC_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_b0   = r_b0;
    assign o_b1   = r_b1;
    assign o_b2   = r_b2;
    assign o_a1   = r_a1;
    assign o_a2   = r_a2;
    assign o_frac = r_frac;

endmodule

// ----- hw/rtl/cbiq_lane.sv -----
// One real-valued direct-form-I section: history, multiply-accumulate, shift, saturate.
module cbiq_lane #(
    parameter int COEF_WIDTH   = cbiq_pkg::COEF_WIDTH_DEF,
    parameter int SAMPLE_WIDTH = cbiq_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_x0,
    input  logic signed [COEF_WIDTH-1:0]      i_b0,
    input  logic signed [COEF_WIDTH-1:0]      i_b1,
    input  logic signed [COEF_WIDTH-1:0]      i_b2,
    input  logic signed [COEF_WIDTH-1:0]      i_a1,
    input  logic signed [COEF_WIDTH-1:0]      i_a2,
    input  logic [cbiq_pkg::FRAC_W-1:0]       i_frac,
    output logic signed [SAMPLE_WIDTH-1:0]    o_y
);

    localparam int PROD_W = COEF_WIDTH + SAMPLE_WIDTH;
    localparam int ACC_W  = PROD_W + 3;
    localparam int TOP_W  = ACC_W - SAMPLE_WIDTH + 1;

    localparam logic signed [SAMPLE_WIDTH-1:0] SAT_HI = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAT_LO = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    logic signed [SAMPLE_WIDTH-1:0] r_x1, r_x2, r_y1, r_y2;

    logic signed [PROD_W-1:0] w_p0, w_p1, w_p2, w_p3, w_p4;
    logic signed [ACC_W-1:0]  w_acc;
    logic signed [ACC_W-1:0]  w_sh;
    logic [TOP_W-1:0]         w_top;
    logic                     w_ovf;

    assign w_p0 = PROD_W'(i_b0) * PROD_W'(i_x0);
    assign w_p1 = PROD_W'(i_b1) * PROD_W'(r_x1);
    assign w_p2 = PROD_W'(i_b2) * PROD_W'(r_x2);
    assign w_p3 = PROD_W'(i_a1) * PROD_W'(r_y1);
    assign w_p4 = PROD_W'(i_a2) * PROD_W'(r_y2);

    assign w_acc = ACC_W'(w_p0) + ACC_W'(w_p1) + ACC_W'(w_p2)
                 + ACC_W'(w_p3) + ACC_W'(w_p4);

    // arithmetic shift floors toward minus infinity
    assign w_sh  = w_acc >>> i_frac;
    assign w_top = w_sh[ACC_W-1:SAMPLE_WIDTH-1];
    assign w_ovf = !((&w_top) || !(|w_top));

    always_comb begin
        if (w_ovf) begin
            o_y = w_sh[ACC_W-1] ? SAT_LO : SAT_HI;
        end else begin
            o_y = w_sh[SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1 <= '0;
            r_x2 <= '0;
            r_y1 <= '0;
            r_y2 <= '0;
        end else if (i_adv) begin
            r_x1 <= i_x0;
            r_x2 <= r_x1;
            r_y1 <= o_y;
            r_y2 <= r_y1;
        end
    end

endmodule

// ----- hw/rtl/complex_biquad_iir_filter_unit.sv -----
// Top level of the complex biquad IIR filter unit.
// Filters a stream of complex samples through one direct-form-I second-order
// section, the real and imaginary parts independently with the same five
// coefficients (feedback terms added). One item is accepted per clock while the
// output is not stalled; an accepted item waits in the input register while the
// multiply-accumulate, floor shift by coef_frac_bits and saturation settle, and
// its result then goes to the result register and the output. The recursive
// update of the output history in that single step sets the rate at one item
// per clock. A stalled output holds the result register and then the input
// register, so at most two items are in flight. The user must write coefficients
// through the configuration port only while the stream is idle; the block does not enforce it.
module complex_biquad_iir_filter_unit #(
    parameter int COEF_WIDTH   = cbiq_pkg::COEF_WIDTH_DEF,
    parameter int SAMPLE_WIDTH = cbiq_pkg::SAMPLE_WIDTH_DEF,
    parameter int DATA_W       = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cbiq_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [COEF_WIDTH-1:0]             i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [DATA_W-1:0]                 s_axis_tdata,  // sample_real, sample_imag
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [DATA_W-1:0]                 m_axis_tdata   // result_real, result_imag
);

    logic signed [COEF_WIDTH-1:0] w_b0, w_b1, w_b2, w_a1, w_a2;
    logic [cbiq_pkg::FRAC_W-1:0]  w_frac;

    logic                           r_in_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_in_re, r_in_im;
    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_re, r_out_im;

    logic                           w_in_acc;
    logic                           w_adv;
    logic signed [SAMPLE_WIDTH-1:0] w_y_re, w_y_im;

    cbiq_cfg #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_b0       (w_b0),
        .o_b1       (w_b1),
        .o_b2       (w_b2),
        .o_a1       (w_a1),
        .o_a2       (w_a2),
        .o_frac     (w_frac)
    );

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_re <= s_axis_tdata[SAMPLE_WIDTH-1:0];
            r_in_im <= s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
        end
    end

    cbiq_lane #(
        .COEF_WIDTH   (COEF_WIDTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_lane_re (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_x0    (r_in_re),
        .i_b0    (w_b0),
        .i_b1    (w_b1),
        .i_b2    (w_b2),
        .i_a1    (w_a1),
        .i_a2    (w_a2),
        .i_frac  (w_frac),
        .o_y     (w_y_re)
    );

    cbiq_lane #(
        .COEF_WIDTH   (COEF_WIDTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_lane_im (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_x0    (r_in_im),
        .i_b0    (w_b0),
        .i_b1    (w_b1),
        .i_b2    (w_b2),
        .i_a1    (w_a1),
        .i_a2    (w_a2),
        .i_frac  (w_frac),
        .o_y     (w_y_im)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_re <= w_y_re;
            r_out_im <= w_y_im;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = DATA_W'({r_out_im, r_out_re});

    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> r_in_valid)
        else $error("input register item dropped while stalled");

    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("advanced item missing from result register");

    a_accept_fills_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_in_valid)
        else $error("accepted item missing from input register");

endmodule
